@@ design/mcpwm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpwm_pkg: shared types and constants of the multi-channel PWM generator
// Holds stream layouts, action and status codes, the sequencer states and
// the small structs passed between the top level and the phase step unit.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

  localparam int PIN_W     = 6;
  localparam int IN_TIME_W = 24;

  // Input beat layout: tdata = pin, period_units, high_units (lowest first)
  localparam int S_PIN_LSB  = 0;
  localparam int S_PER_LSB  = S_PIN_LSB + PIN_W;
  localparam int S_HI_LSB   = S_PER_LSB + IN_TIME_W;
  localparam int S_USED_W   = S_HI_LSB + IN_TIME_W;
  localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
  localparam int S_TUSER_W  = 2;

  // Output beat layout: tdata = out_pin, level (lowest first)
  localparam int M_USED_W   = PIN_W + 1;
  localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_DISABLE = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_CHANGE    = 2'd0,
    ST_SET_OK    = 2'd1,
    ST_REJECT    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             level;
    status_e          status;
  } res_t;

  typedef struct packed {
    logic fire;
    logic level;
  } evt_t;

endpackage

@@ design/mcpwm_phase_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpwm_phase_step: one timer-unit advance of a single channel
// Steps the phase with wrap at the period and flags the level edge, if any.
// ----------------------------------------------------------------------------
module mcpwm_phase_step #(
  parameter int TIME_WIDTH = 24
) (
  input  logic [TIME_WIDTH-1:0] period_i,
  input  logic [TIME_WIDTH-1:0] high_i,
  input  logic [TIME_WIDTH-1:0] phase_i,
  output logic [TIME_WIDTH-1:0] phase_o,
  output mcpwm_pkg::evt_t       evt_o
);
  import mcpwm_pkg::*;

  logic [TIME_WIDTH:0] inc;
  logic                wrap;

  // Phase stays below the period, so wrap is a single compare
  assign inc     = {1'b0, phase_i} + {{TIME_WIDTH{1'b0}}, 1'b1};
  assign wrap    = (inc == {1'b0, period_i});
  assign phase_o = wrap ? '0 : inc[TIME_WIDTH-1:0];

  // Zero high time keeps the pin low: no edge at all
  assign evt_o.fire  = (high_i != '0) && ((phase_o == '0) || (phase_o == high_i));
  assign evt_o.level = (phase_o == '0);

endmodule

@@ design/multi_channel_pwm_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator_unit: table-driven multi-channel PWM generator
// Keeps up to CHANNELS pin-keyed PWM channels in one synchronous RAM and
// reports every level change, set answer and disable answer as a beat.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tuser           | tdata (lowest bit up)             | tlast
//  ---------+-----------+-----------------+-----------------------------------+---------
//  s_axis   | in        | action [1:0]    | pin[5:0], period_units[29:6],     | -
//           |           |                 | high_units[53:30], zero [55:54]   |
//  m_axis   | out       | status [1:0]    | out_pin[5:0], level[6], zero[7]   | last
//
// A tick scans all entries present, a set or disable up to its pin, in order
// before the next acceptance; a tick on an empty table returns straight to
// idle. The scan runs through the single read port of the channel RAM, which
// visits one entry a cycle unless a stalled m_axis holds a tick's scan back.
// A set with zero period writes no entry and adds none.
// Reset clears the enable bits, the entry count and all control state; the
// RAM contents need no clearing, as only entries below the count are used.
// A stalled m_axis holds back a tick's scan only when a further level change
// is found while the previous one still waits; one result is buffered.
// ----------------------------------------------------------------------------
module multi_channel_pwm_generator_unit #(
  parameter int CHANNELS   = 8,
  parameter int TIME_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tuser: action[1:0]
  // tdata: pin[5:0], period_units[29:6], high_units[53:30], pad[55:54]
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [mcpwm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [mcpwm_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  // tuser: status[1:0]
  // tdata: out_pin[5:0], level[6], pad[7]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [mcpwm_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [mcpwm_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import mcpwm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int ENT_W = PIN_W + 3 * TIME_WIDTH;
  // Entry layout, lowest first: pin, period, high, phase
  localparam int E_PER = PIN_W;
  localparam int E_HI  = PIN_W + TIME_WIDTH;
  localparam int E_PH  = PIN_W + 2 * TIME_WIDTH;

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  logic                  s_acc;
  act_e                  in_act;
  logic [PIN_W-1:0]      in_pin;
  logic [TIME_WIDTH-1:0] in_per;
  logic [TIME_WIDTH-1:0] in_hi;

  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_act = act_e'(s_axis_tuser_i);
  assign in_pin = s_axis_tdata_i[S_PIN_LSB +: PIN_W];
  // Time values are kept modulo 2^TIME_WIDTH
  assign in_per = TIME_WIDTH'(s_axis_tdata_i[S_PER_LSB +: IN_TIME_W]);
  assign in_hi  = TIME_WIDTH'(s_axis_tdata_i[S_HI_LSB +: IN_TIME_W]);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  act_e                  act_q;
  logic [PIN_W-1:0]      pin_q;
  logic [TIME_WIDTH-1:0] per_q;
  logic [TIME_WIDTH-1:0] hi_q;
  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CHANNELS-1:0]   en_q, en_d;
  logic                  pend_v_q;
  res_t                  pend_q;
  logic                  m_valid_q;
  res_t                  m_res_q;
  logic                  m_last_q;

  // Channel RAM, one read and one write port, registered read data
  logic [ENT_W-1:0]      chan_mem [CHANNELS];
  logic [ENT_W-1:0]      rd_q;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_ra;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [ENT_W-1:0]      mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chan_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= chan_mem[mem_ra];
    end
  end

  // --------------------------------------------------------------------------
  // Entry decode and per-entry decisions
  // --------------------------------------------------------------------------
  logic [PIN_W-1:0]      ent_pin;
  logic [TIME_WIDTH-1:0] ent_per;
  logic [TIME_WIDTH-1:0] ent_hi;
  logic [TIME_WIDTH-1:0] ent_ph;
  logic [TIME_WIDTH-1:0] ph_next;
  evt_t                  evt;
  logic [CNT_W-1:0]      idx_inc;
  logic                  last_ent;
  logic                  pin_hit;
  logic                  slot_free;
  logic                  tick_stall;
  logic                  timing_same;

  assign ent_pin = rd_q[0 +: PIN_W];
  assign ent_per = rd_q[E_PER +: TIME_WIDTH];
  assign ent_hi  = rd_q[E_HI +: TIME_WIDTH];
  assign ent_ph  = rd_q[E_PH +: TIME_WIDTH];

  mcpwm_phase_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .period_i (ent_per),
    .high_i   (ent_hi),
    .phase_i  (ent_ph),
    .phase_o  (ph_next),
    .evt_o    (evt)
  );

  assign idx_inc     = CNT_W'(idx_q) + CNT_W'(1);
  assign last_ent    = !(idx_inc < cnt_q);
  assign pin_hit     = (ent_pin == pin_q);
  assign slot_free   = !m_valid_q || m_axis_tready_i;
  assign timing_same = (ent_per == per_q) && (ent_hi == hi_q);
  // Hold the scan while a new edge finds the buffered one still waiting
  assign tick_stall  = (act_q == ACT_TICK) && en_q[idx_q] && evt.fire &&
                       pend_v_q && !slot_free;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          unique case (in_act)
            ACT_TICK:    state_d = (cnt_q == '0) ? S_IDLE : S_SCAN;
            ACT_SET: begin
              if (in_per == '0) begin
                state_d = S_FLUSH;
              end else begin
                state_d = (cnt_q == '0) ? S_RESOLVE : S_SCAN;
              end
            end
            ACT_DISABLE: state_d = (cnt_q == '0) ? S_RESOLVE : S_SCAN;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (act_q == ACT_TICK) begin
          if (!tick_stall && last_ent) begin
            state_d = S_FLUSH;
          end
        end else if (pin_hit) begin
          state_d = S_FLUSH;
        end else if (last_ent) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: state_d = S_FLUSH;
      S_FLUSH: begin
        if (!pend_v_q || slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  logic idx_clr;
  logic idx_adv;
  logic pend_ld;
  logic pend_clr;
  res_t pend_d;
  logic push;
  logic push_last;

  always_comb begin
    mem_re    = 1'b0;
    mem_ra    = '0;
    mem_we    = 1'b0;
    mem_wa    = idx_q;
    mem_wd    = {ent_ph, ent_hi, ent_per, ent_pin};
    en_d      = en_q;
    cnt_d     = cnt_q;
    idx_clr   = 1'b0;
    idx_adv   = 1'b0;
    pend_ld   = 1'b0;
    pend_clr  = 1'b0;
    pend_d    = '{pin: pin_q, level: 1'b0, status: ST_SET_OK};
    push      = 1'b0;
    push_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          // Start the scan at entry 0
          mem_re  = 1'b1;
          idx_clr = 1'b1;
          if ((in_act == ACT_SET) && (in_per == '0)) begin
            pend_ld = 1'b1;
            pend_d  = '{pin: in_pin, level: 1'b0, status: ST_REJECT};
          end
        end
      end
      S_SCAN: begin
        if (act_q == ACT_TICK) begin
          if (!tick_stall) begin
            if (en_q[idx_q]) begin
              mem_we = 1'b1;
              mem_wd = {ph_next, ent_hi, ent_per, ent_pin};
              if (evt.fire) begin
                // Release the previous edge, buffer this one
                push    = pend_v_q;
                pend_ld = 1'b1;
                pend_d  = '{pin: ent_pin, level: evt.level, status: ST_CHANGE};
              end
            end
            if (!last_ent) begin
              mem_re  = 1'b1;
              mem_ra  = idx_inc[IDX_W-1:0];
              idx_adv = 1'b1;
            end
          end
        end else if (pin_hit) begin
          pend_ld = 1'b1;
          if (act_q == ACT_SET) begin
            mem_we = 1'b1;
            mem_wd = {(timing_same ? ent_ph : '0), hi_q, per_q, ent_pin};
            en_d[idx_q] = 1'b1;
            pend_d = '{pin: pin_q, level: 1'b0, status: ST_SET_OK};
          end else begin
            en_d[idx_q] = 1'b0;
            pend_d = '{pin: pin_q, level: 1'b0, status: ST_CHANGE};
          end
        end else if (!last_ent) begin
          mem_re  = 1'b1;
          mem_ra  = idx_inc[IDX_W-1:0];
          idx_adv = 1'b1;
        end
      end
      S_RESOLVE: begin
        pend_ld = 1'b1;
        if (act_q == ACT_SET) begin
          if (cnt_q < CNT_W'(CHANNELS)) begin
            // Append a new channel at the end of the table
            mem_we = 1'b1;
            mem_wa = cnt_q[IDX_W-1:0];
            mem_wd = {{TIME_WIDTH{1'b0}}, hi_q, per_q, pin_q};
            en_d[cnt_q[IDX_W-1:0]] = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            pend_d = '{pin: pin_q, level: 1'b0, status: ST_SET_OK};
          end else begin
            pend_d = '{pin: pin_q, level: 1'b0, status: ST_REJECT};
          end
        end else begin
          pend_d = '{pin: pin_q, level: 1'b0, status: ST_NOT_FOUND};
        end
      end
      S_FLUSH: begin
        if (pend_v_q && slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_clr  = 1'b1;
        end
      end
      default: begin
        pend_clr = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      en_q      <= '0;
      pend_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      en_q    <= en_d;
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_adv) begin
        idx_q <= idx_inc[IDX_W-1:0];
      end
      if (pend_ld) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      act_q <= in_act;
      pin_q <= in_pin;
      per_q <= in_per;
      hi_q  <= in_hi;
    end
    if (pend_ld) begin
      pend_q <= pend_d;
    end
    if (push) begin
      m_res_q  <= pend_q;
      m_last_q <= push_last;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - M_USED_W){1'b0}}, m_res_q.level, m_res_q.pin};
  assign m_axis_tuser_o  = m_res_q.status;
  assign m_axis_tlast_o  = m_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CHANNELS))
    else $error("channel count beyond table depth");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("buffered result left behind on return to idle");

  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_act == ACT_SET) && (in_per == '0)) |=>
      (pend_v_q && (pend_q.status == ST_REJECT) && (cnt_q == $past(cnt_q))))
    else $error("zero period set not rejected");

  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_SCAN)) |-> (mem_wa == idx_q) && !(mem_re && mem_ra == idx_q))
    else $error("write-back collides with read of the same entry");

endmodule

@@ tb/tb_multi_channel_pwm_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_pwm_generator_unit: self-checking bench for the PWM table
// Drives tick, set, disable and unused actions into the slave stream and
// checks every master beat against an in-bench copy of the channel table.
// A short directed table comes first, then a long random run.
// ----------------------------------------------------------------------------
module tb_multi_channel_pwm_generator_unit;
  import mcpwm_pkg::*;

  localparam int         N_CHAN     = 8;
  localparam int         T_W        = 24;
  localparam logic [1:0] ACT_UNUSED = 2'd3;   // no operation: item is dropped
  localparam int         N_RANDOM   = 185;
  localparam int         DRAIN_CYC  = 32;     // a few times the longest scan

  // One row of directed stimulus; typed rows carry their single answer beat
  typedef struct {
    logic [1:0]       act;
    logic [PIN_W-1:0] pin;
    logic [T_W-1:0]   per;
    logic [T_W-1:0]   hi;
    logic             typed;
    status_e          st;
    logic             lvl;
  } stim_row_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             level;
    status_e          status;
    logic             last;
  } pwm_beat_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // tdata: pin[5:0], period_units[29:6], high_units[53:30], pad[55:54]
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  // tuser: action[1:0]
  logic [S_TUSER_W-1:0] s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // tdata: out_pin[5:0], level[6], pad[7]
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  // tuser: status[1:0]
  logic [M_TUSER_W-1:0] m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // Mirror of the channel table, kept in step with every accepted beat
  logic [PIN_W-1:0] tbl_pin    [N_CHAN];
  logic [T_W-1:0]   tbl_period [N_CHAN];
  logic [T_W-1:0]   tbl_high   [N_CHAN];
  logic [T_W-1:0]   tbl_phase  [N_CHAN];
  logic             tbl_en     [N_CHAN];
  int               tbl_count = 0;

  pwm_beat_t pending_beats[$];   // answers still owed by the block, oldest first
  pwm_beat_t step_beats[$];      // answers caused by the item just accepted
  stim_row_t dir_rows[$];

  int n_fail  = 0;
  int n_sent  = 0;
  int n_beats = 0;

  always #4 clk_i = ~clk_i;

  multi_channel_pwm_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic void add_beat(logic [PIN_W-1:0] pin, logic lvl, status_e st);
    step_beats.push_back('{pin, lvl, st, 1'b0});
  endfunction

  // Advance the mirrored table by one item and collect the beats it causes
  function automatic void pwm_step(logic [1:0] act, logic [PIN_W-1:0] pin,
                                   logic [T_W-1:0] per, logic [T_W-1:0] hi);
    int         idx;
    logic [T_W:0] nxt;
    step_beats.delete();
    idx = -1;
    for (int i = 0; i < tbl_count; i++)
      if (idx < 0 && tbl_pin[i] == pin) idx = i;
    case (act)
      ACT_TICK: begin
        // walk the table in order; the phase wraps at the period
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_en[i] && tbl_period[i] != '0) begin
            nxt = {1'b0, tbl_phase[i]} + 1'b1;
            tbl_phase[i] = (nxt == {1'b0, tbl_period[i]}) ? '0 : nxt[T_W-1:0];
            if (tbl_high[i] != '0) begin
              if (tbl_phase[i] == '0)
                add_beat(tbl_pin[i], 1'b1, ST_CHANGE);
              else if (tbl_phase[i] == tbl_high[i])
                add_beat(tbl_pin[i], 1'b0, ST_CHANGE);
            end
          end
        end
      end
      ACT_SET: begin
        if (per == '0) begin
          add_beat(pin, 1'b0, ST_REJECT);
        end else if (idx >= 0) begin
          // restart the phase only when the timing really changes
          if (tbl_period[idx] != per || tbl_high[idx] != hi) tbl_phase[idx] = '0;
          tbl_period[idx] = per;
          tbl_high[idx]   = hi;
          tbl_en[idx]     = 1'b1;
          add_beat(pin, 1'b0, ST_SET_OK);
        end else if (tbl_count < N_CHAN) begin
          tbl_pin[tbl_count]    = pin;
          tbl_period[tbl_count] = per;
          tbl_high[tbl_count]   = hi;
          tbl_phase[tbl_count]  = '0;
          tbl_en[tbl_count]     = 1'b1;
          tbl_count++;
          add_beat(pin, 1'b0, ST_SET_OK);
        end else begin
          add_beat(pin, 1'b0, ST_REJECT);
        end
      end
      ACT_DISABLE: begin
        if (idx >= 0) begin
          tbl_en[idx] = 1'b0;
          add_beat(pin, 1'b0, ST_CHANGE);
        end else begin
          add_beat(pin, 1'b0, ST_NOT_FOUND);
        end
      end
      default: ;
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(logic [1:0] act, logic [PIN_W-1:0] pin,
                                  logic [T_W-1:0] per, logic [T_W-1:0] hi,
                                  logic typed, status_e st, logic lvl);
    stim_row_t r;
    r.act   = act;
    r.pin   = pin;
    r.per   = per;
    r.hi    = hi;
    r.typed = typed;
    r.st    = st;
    r.lvl   = lvl;
    dir_rows.push_back(r);
  endfunction

  // Present one item after a random gap and hold it until tready; on the
  // accepting edge advance the mirror and queue the answers it owes.
  task automatic send_item(input logic [1:0] act, input logic [PIN_W-1:0] pin,
                           input logic [T_W-1:0] per, input logic [T_W-1:0] hi,
                           input logic typed, input status_e st, input logic lvl);
    int gap;
    // every fourth run of twenty items goes back to back
    gap = ((n_sent / 20) % 4 == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= S_TDATA_W'({hi, per, pin});
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
    pwm_step(act, pin, per, hi);
    if (typed)
      pending_beats.push_back('{pin, lvl, st, 1'b1});
    else
      foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
  endtask

  // Master side: stall a random number of cycles per beat, then take it and
  // compare field by field with the oldest owed answer.
  initial begin : result_side
    int        stall;
    pwm_beat_t want;
    wait (rst_ni);
    forever begin
      stall = ((n_beats / 24) % 4 == 2) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      n_beats++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_pin %0d level %0d status %0d last %0d",
               m_axis_tdata_o[PIN_W-1:0], m_axis_tdata_o[PIN_W], m_axis_tuser_o,
               m_axis_tlast_o);
        n_fail++;
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata_o[PIN_W-1:0] !== want.pin) begin
          $error("out_pin: expected %0d, got %0d", want.pin, m_axis_tdata_o[PIN_W-1:0]);
          n_fail++;
        end
        if (m_axis_tdata_o[PIN_W] !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, m_axis_tdata_o[PIN_W]);
          n_fail++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          n_fail++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          n_fail++;
        end
      end
    end
  end

  initial begin : stimulus
    int               n_rand;
    int               sel;
    logic [1:0]       act;
    logic [PIN_W-1:0] pin;
    logic [T_W-1:0]   per;
    logic [T_W-1:0]   hi;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty-table answers, every action, the special timings
    // (zero high, high beyond period, period of one), a repeat set without and
    // a re-enable with a timing change, a full table and the widest time values.
    add_row(ACT_DISABLE, 6'd5,  24'd0,      24'd0,      1'b1, ST_NOT_FOUND, 1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_SET,     6'd0,  24'd0,      24'd3,      1'b1, ST_REJECT,    1'b0);
    add_row(ACT_SET,     6'd0,  24'd4,      24'd2,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd63, 24'd1,      24'd1,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd10, 24'd3,      24'd0,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd20, 24'd2,      24'd5,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_SET,     6'd0,  24'd4,      24'd2,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_DISABLE, 6'd0,  24'd0,      24'd0,      1'b1, ST_CHANGE,    1'b0);
    add_row(ACT_DISABLE, 6'd0,  24'd0,      24'd0,      1'b1, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_SET,     6'd0,  24'd5,      24'd2,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd30, 24'hFFFFFF, 24'hFFFFFF, 1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd31, 24'd1,      24'd0,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd32, 24'd2,      24'd1,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd33, 24'd3,      24'd3,      1'b1, ST_SET_OK,    1'b0);
    add_row(ACT_SET,     6'd40, 24'd3,      24'd1,      1'b1, ST_REJECT,    1'b0);
    add_row(ACT_UNUSED,  6'd63, 24'hFFFFFF, 24'hFFFFFF, 1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);
    add_row(ACT_TICK,    6'd0,  24'd0,      24'd0,      1'b0, ST_CHANGE,    1'b0);

    foreach (dir_rows[r])
      send_item(dir_rows[r].act, dir_rows[r].pin, dir_rows[r].per, dir_rows[r].hi,
                dir_rows[r].typed, dir_rows[r].st, dir_rows[r].lvl);

    // Random part: mostly ticks and retimings of known pins with short
    // periods so that level changes keep flowing; the rest covers wide time
    // values, zero periods, unknown pins, disables and unused codes.
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      sel = $urandom_range(0, 99);
      pin = PIN_W'($urandom_range(0, 63));
      per = T_W'($urandom);
      hi  = T_W'($urandom);
      if (sel < 52) begin
        act = ACT_TICK;
      end else if (sel < 76) begin
        act = ACT_SET;
        if (tbl_count > 0) pin = tbl_pin[$urandom_range(0, tbl_count - 1)];
        per = T_W'($urandom_range(1, 6));
        hi  = T_W'($urandom_range(0, 7));
      end else if (sel < 82) begin
        // wide timing, on a known pin half the time; now and then a zero period
        act = ACT_SET;
        if (tbl_count > 0 && $urandom_range(0, 1) == 1)
          pin = tbl_pin[$urandom_range(0, tbl_count - 1)];
        if ($urandom_range(0, 3) == 0) per = '0;
      end else if (sel < 88) begin
        act = ACT_SET;
        per = T_W'($urandom_range(1, 6));
        hi  = T_W'($urandom_range(0, 7));
      end else if (sel < 96) begin
        act = ACT_DISABLE;
        if (tbl_count > 0 && $urandom_range(0, 2) != 0)
          pin = tbl_pin[$urandom_range(0, tbl_count - 1)];
      end else begin
        act = ACT_UNUSED;
      end
      send_item(act, pin, per, hi, 1'b0, ST_CHANGE, 1'b0);
      if (act != ACT_UNUSED) n_rand++;
    end
    s_axis_tvalid_i <= 1'b0;

    // Hold until every owed beat has arrived, then watch for strays
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
